// ===== sv/lbps_pkg.sv =====
// Shared types and constants for the LED and button panel scanner.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package lbps_pkg;

    // width of the button readback and of the shown frame
    localparam int FIELD_BITS = 24;
    localparam int KEY_BITS   = 5;

    // opcodes
    localparam logic [3:0] OP_TICK     = 4'd0;
    localparam logic [3:0] OP_SET_BG   = 4'd1;
    localparam logic [3:0] OP_CLR_BG   = 4'd2;
    localparam logic [3:0] OP_SET_BL   = 4'd3;
    localparam logic [3:0] OP_CLR_BL   = 4'd4;
    localparam logic [3:0] OP_SET_OV   = 4'd5;
    localparam logic [3:0] OP_CLR_OV   = 4'd6;
    localparam logic [3:0] OP_WIPE_BG  = 4'd7;
    localparam logic [3:0] OP_WIPE_BL  = 4'd8;
    localparam logic [3:0] OP_WIPE_ALL = 4'd9;

    localparam logic [7:0] BLINK_TICKS_RST = 8'd20;

    typedef struct packed {
        logic [3:0]            opcode;
        logic [7:0]            led_number;
        logic [FIELD_BITS-1:0] raw_buttons;
    } in_item_t;

    typedef struct packed {
        logic [FIELD_BITS-1:0] led_pattern;
        logic                  key_valid;
        logic [KEY_BITS-1:0]   key_number;
        logic                  key_pressed;
        logic                  last;
    } out_item_t;

    // one tick handed from the front to the back
    typedef struct packed {
        logic [FIELD_BITS-1:0] pattern;
        logic [FIELD_BITS-1:0] diff;
        logic [FIELD_BITS-1:0] buttons;
    } job_t;

endpackage

`default_nettype wire

// ===== sv/led_button_panel_scanner_core.sv =====
// Top level of the LED and button panel scanner.
// Depends on lbps_pkg, lbps_front, lbps_job_fifo and lbps_back.
//
// channel   | handshake        | payload
// ----------+------------------+---------------------------------
// input     | push / full      | item   (opcode, led_number, raw_buttons)
// result    | empty / pop      | result (led_pattern, key_* , last)
// config    | cfg_wr           | cfg_data (blink_ticks)
//
// LED operations are applied in the front end and give no result.
// A tick is taken as a job; the back end then loads the job and sends the
// frame and one event per changed button, each when the result slot is free.
// Two tick jobs can wait between front and back; full rises when both wait.
// Reset clears all maps, button history, blink counter and phase;
// blink_ticks returns to 20.
`timescale 1ns / 1ps
`default_nettype none

module led_button_panel_scanner_core #(
    parameter int PANELS = 3
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire lbps_pkg::in_item_t  item,
    output logic                     full,
    output lbps_pkg::out_item_t      result,
    output logic                     empty,
    input  wire logic                pop,
    input  wire logic                cfg_wr,
    input  wire logic [7:0]          cfg_data
);

    logic           job_wr;
    lbps_pkg::job_t job_in;
    logic           job_full;
    logic           job_rd;
    lbps_pkg::job_t job_out;
    logic           job_empty;

    // front end
    lbps_front #(
        .PANELS (PANELS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item     (item),
        .full     (full),
        .cfg_wr   (cfg_wr),
        .cfg_data (cfg_data),
        .job_wr   (job_wr),
        .job      (job_in),
        .job_full (job_full)
    );

    // job queue
    lbps_job_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_wr),
        .wr_data (job_in),
        .full    (job_full),
        .rd_en   (job_rd),
        .rd_data (job_out),
        .empty   (job_empty)
    );

    // back end
    lbps_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (job_out),
        .job_empty (job_empty),
        .job_rd    (job_rd),
        .result    (result),
        .empty     (empty),
        .pop       (pop)
    );

endmodule

`default_nettype wire

// ===== sv/lbps_job_fifo.sv =====
// Two-entry queue of tick jobs between the front and the back.
// Depends on lbps_pkg for job_t.
`timescale 1ns / 1ps
`default_nettype none

module lbps_job_fifo (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  wire lbps_pkg::job_t wr_data,
    output logic               full,
    input  wire logic          rd_en,
    output lbps_pkg::job_t     rd_data,
    output logic               empty
);

    lbps_pkg::job_t mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign rd_data = mem[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !full)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (rd_en && !empty)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if ((wr_en && !full) && !(rd_en && !empty))
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!(wr_en && !full) && (rd_en && !empty))
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage write
    always_ff @(posedge clk)
    begin
        if (wr_en && !full)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ===== sv/lbps_front.sv =====
// Front end: takes items, keeps LED maps, button state and blink phase,
// and turns each tick into a job for the back end. Depends on lbps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lbps_front #(
    parameter int PANELS = 3
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire lbps_pkg::in_item_t item,
    output logic                    full,
    input  wire logic               cfg_wr,
    input  wire logic [7:0]         cfg_data,
    output logic                    job_wr,
    output lbps_pkg::job_t          job,
    input  wire logic               job_full
);

    localparam int MAP_BITS = 8 * PANELS;
    localparam int IDX_W    = $clog2(MAP_BITS);
    localparam int FB       = lbps_pkg::FIELD_BITS;
    localparam logic [8:0] MAP_TOP = 9'(MAP_BITS - 1);
    localparam logic [MAP_BITS+FB-1:0] ONES_PAD = {{FB{1'b0}}, {MAP_BITS{1'b1}}};
    localparam logic [FB-1:0] SCAN_MASK = ONES_PAD[FB-1:0];

    logic [MAP_BITS-1:0] bg_reg, bg_next;
    logic [MAP_BITS-1:0] bl_reg, bl_next;
    logic [MAP_BITS-1:0] ov_reg, ov_next;
    logic [FB-1:0]       prev_reg, prev_next;
    logic [7:0]          cnt_reg, cnt_next;
    logic                phase_reg, phase_next;
    logic [7:0]          ticks_reg;

    logic                accept;
    logic [8:0]          pos9;
    logic                in_range;
    logic [MAP_BITS-1:0] mask;
    logic [MAP_BITS-1:0] frame;
    logic [MAP_BITS+FB-1:0] frame_pad;
    logic [FB-1:0]       nb;
    logic [7:0]          cnt_inc;

    assign full   = job_full;
    assign accept = push && !job_full;

    // led number n sits at bit MAP_BITS-1-n of the flat map
    assign pos9     = MAP_TOP - {1'b0, item.led_number};
    assign in_range = ({1'b0, item.led_number} <= MAP_TOP);
    always_comb
    begin
        mask = '0;
        if (in_range)
        begin
            mask[pos9[IDX_W-1:0]] = 1'b1;
        end
    end

    // frame and button change
    assign frame     = phase_reg ? ((bg_reg ^ ov_reg) | bl_reg)
                                 : ((bg_reg ^ ov_reg) & ~bl_reg);
    assign frame_pad = {{FB{1'b0}}, frame};
    assign nb        = ~item.raw_buttons & SCAN_MASK;
    assign cnt_inc   = cnt_reg + 8'd1;

    assign job.pattern = frame_pad[FB-1:0];
    assign job.diff    = nb ^ prev_reg;
    assign job.buttons = nb;
    assign job_wr      = accept && (item.opcode == lbps_pkg::OP_TICK);

    // map and blink state update
    always_comb
    begin
        bg_next    = bg_reg;
        bl_next    = bl_reg;
        ov_next    = ov_reg;
        prev_next  = prev_reg;
        cnt_next   = cnt_reg;
        phase_next = phase_reg;
        if (accept)
        begin
            unique case (item.opcode)
                lbps_pkg::OP_TICK:
                begin
                    prev_next = nb;
                    if (cnt_inc >= ticks_reg)
                    begin
                        cnt_next   = 8'd0;
                        phase_next = ~phase_reg;
                    end
                    else
                    begin
                        cnt_next = cnt_inc;
                    end
                end
                lbps_pkg::OP_SET_BG:   bg_next = bg_reg | mask;
                lbps_pkg::OP_CLR_BG:   bg_next = bg_reg & ~mask;
                lbps_pkg::OP_SET_BL:   bl_next = bl_reg | mask;
                lbps_pkg::OP_CLR_BL:   bl_next = bl_reg & ~mask;
                lbps_pkg::OP_SET_OV:   ov_next = ov_reg | mask;
                lbps_pkg::OP_CLR_OV:   ov_next = ov_reg & ~mask;
                lbps_pkg::OP_WIPE_BG:  bg_next = '0;
                lbps_pkg::OP_WIPE_BL:  bl_next = '0;
                lbps_pkg::OP_WIPE_ALL:
                begin
                    bg_next = '0;
                    bl_next = '0;
                    ov_next = '0;
                end
                default:
                begin
                    bg_next = bg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bg_reg    <= '0;
            bl_reg    <= '0;
            ov_reg    <= '0;
            prev_reg  <= '0;
            cnt_reg   <= 8'd0;
            phase_reg <= 1'b0;
            ticks_reg <= lbps_pkg::BLINK_TICKS_RST;
        end
        else
        begin
            bg_reg    <= bg_next;
            bl_reg    <= bl_next;
            ov_reg    <= ov_next;
            prev_reg  <= prev_next;
            cnt_reg   <= cnt_next;
            phase_reg <= phase_next;
            if (cfg_wr)
            begin
                ticks_reg <= cfg_data;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/lbps_back.sv =====
// Back end: pulls tick jobs and sends the frame, then one event per
// changed button in ascending order, through an output register.
// Depends on lbps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lbps_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire lbps_pkg::job_t job,
    input  wire logic           job_empty,
    output logic                job_rd,
    output lbps_pkg::out_item_t result,
    output logic                empty,
    input  wire logic           pop
);

    localparam int FB = lbps_pkg::FIELD_BITS;
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FRAME = 2'd1;
    localparam logic [1:0] ST_EVENT = 2'd2;

    logic [1:0]          state_reg, state_next;
    lbps_pkg::job_t      work_reg, work_next;
    lbps_pkg::out_item_t out_reg, out_next;
    logic                out_valid_reg, out_valid_next;

    logic                slot_free;
    logic [lbps_pkg::KEY_BITS-1:0] low_idx;
    logic [FB-1:0]       diff_rest;

    assign empty     = !out_valid_reg;
    assign result    = out_reg;
    assign slot_free = !out_valid_reg || pop;
    assign diff_rest = work_reg.diff & (work_reg.diff - FB'(1));

    // lowest changed button
    always_comb
    begin
        low_idx = '0;
        for (int i = FB - 1; i >= 0; i--)
        begin
            if (work_reg.diff[i])
            begin
                low_idx = lbps_pkg::KEY_BITS'(i);
            end
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        work_next      = work_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !pop;
        job_rd         = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!job_empty)
                begin
                    job_rd     = 1'b1;
                    work_next  = job;
                    state_next = ST_FRAME;
                end
            end
            ST_FRAME:
            begin
                if (slot_free)
                begin
                    out_next.led_pattern = work_reg.pattern;
                    out_next.key_valid   = 1'b0;
                    out_next.key_number  = '0;
                    out_next.key_pressed = 1'b0;
                    out_next.last        = (work_reg.diff == '0);
                    out_valid_next       = 1'b1;
                    state_next = (work_reg.diff == '0) ? ST_IDLE : ST_EVENT;
                end
            end
            ST_EVENT:
            begin
                if (slot_free)
                begin
                    out_next.led_pattern = '0;
                    out_next.key_valid   = 1'b1;
                    out_next.key_number  = low_idx;
                    out_next.key_pressed = work_reg.buttons[low_idx];
                    out_next.last        = (diff_rest == '0);
                    out_valid_next       = 1'b1;
                    work_next.diff       = diff_rest;
                    if (diff_rest == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        out_reg  <= out_next;
    end

endmodule

`default_nettype wire
